@@ sv/keyword_shift_substitution_cipher_defines.svh @@
// assertion macros for the keyword shift substitution cipher checker
// no dependencies
`ifndef KEYWORD_SHIFT_SUBSTITUTION_CIPHER_DEFINES_SVH
`define KEYWORD_SHIFT_SUBSTITUTION_CIPHER_DEFINES_SVH

// same-cycle implication
`define KSSC_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication
`define KSSC_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

@@ sv/kssc_pkg.sv @@
// shared types, constants and helpers for the keyword shift substitution cipher
// no dependencies
package kssc_pkg;

  localparam int ALPHA_SIZE = 26;
  localparam int LETTER_W   = 5;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_ENCODE = 2'd2
  } func_t;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef letter_t [ALPHA_SIZE-1:0] letter_vec_t;

  // key state as seen by the mapping logic
  typedef struct packed {
    logic [ALPHA_SIZE-1:0] used;
    letter_t               length;
    letter_vec_t           order;
    letter_vec_t           below;
  } key_state_t;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= CHAR_A) && (b <= CHAR_Z);
  endfunction

endpackage

@@ sv/kssc_map.sv @@
// combinational letter mapping: shift, key lookup, rank search over free letters
// depends on kssc_pkg
module kssc_map (
  input  logic [7:0]              byte_in,
  input  logic [4:0]              shift_amt,
  input  kssc_pkg::key_state_t    key_st,
  output logic [7:0]              byte_out
);

  logic                            up;
  kssc_pkg::letter_t               idx;
  kssc_pkg::letter_t               dist_m;
  kssc_pkg::letter_t               q;
  kssc_pkg::letter_t               rank;
  logic                            in_key;
  logic [kssc_pkg::ALPHA_SIZE-1:0] hit;
  kssc_pkg::letter_t               free_letter;
  kssc_pkg::letter_t               letter;
  logic [7:0]                      diff;

  always_comb begin
    up     = kssc_pkg::is_upper(byte_in);
    diff   = byte_in - kssc_pkg::CHAR_A;
    idx    = diff[4:0];
    dist_m = (shift_amt >= 5'(kssc_pkg::ALPHA_SIZE))
             ? shift_amt - 5'(kssc_pkg::ALPHA_SIZE) : shift_amt;
    if (idx >= dist_m) begin
      q = idx - dist_m;
    end else begin
      q = idx + 5'(kssc_pkg::ALPHA_SIZE) - dist_m;
    end
    in_key = q < key_st.length;
    rank   = q - key_st.length;
  end

  // a free letter n has rank n minus the key letters below it
  always_comb begin
    free_letter = '0;
    for (int n = 0; n < kssc_pkg::ALPHA_SIZE; n++) begin
      hit[n] = !key_st.used[n] && ((5'(n) - key_st.below[n]) == rank);
      if (hit[n]) begin
        free_letter = free_letter | 5'(n);
      end
    end
  end

  always_comb begin
    letter   = in_key ? key_st.order[q] : free_letter;
    byte_out = up ? (kssc_pkg::CHAR_A + {3'b000, letter}) : byte_in;
  end

endmodule

@@ sv/keyword_shift_substitution_cipher.sv @@
// an accepted item passes the input register and then the result register; throughput: one item
// per cycle, except while an encode in the input register waits behind a stalled result
// input register, then key update or mapping in one pass, then the result register
// clear and append produce no result and never wait on the result side
// reset (rst_n low, synchronous) clears distance, key mask, key length and valids
// the key letter store is not cleared; only entries below the key length are read
module keyword_shift_substitution_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_shift_distance,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte
);

  logic [4:0]                      shift_dist_r;
  logic                            s1_valid_r;
  kssc_pkg::func_t                 s1_func_r;
  logic [7:0]                      s1_byte_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      out_byte_r;
  logic [kssc_pkg::ALPHA_SIZE-1:0] used_r, used_nxt;
  kssc_pkg::letter_t               length_r, length_nxt;
  kssc_pkg::letter_vec_t           order_r, order_nxt;
  kssc_pkg::letter_vec_t           below_r, below_nxt;

  logic                            s1_encode;
  logic                            advance;
  logic                            in_accept;
  logic                            do_step;
  kssc_pkg::key_state_t            key_st;
  logic [7:0]                      map_byte;
  logic [7:0]                      app_diff;
  kssc_pkg::letter_t               app_letter;
  logic                            app_ok;

  assign cfg_ready = 1'b1;

  assign s1_encode = (s1_func_r == kssc_pkg::FUNC_ENCODE);
  assign advance   = !s1_encode || !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign do_step   = s1_valid_r && advance;

  assign key_st.used   = used_r;
  assign key_st.length = length_r;
  assign key_st.order  = order_r;
  assign key_st.below  = below_r;

  kssc_map u_map (
    .byte_in   (s1_byte_r),
    .shift_amt (shift_dist_r),
    .key_st    (key_st),
    .byte_out  (map_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_dist_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      shift_dist_r <= cfg_shift_distance;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r <= kssc_pkg::func_t'(in_func);
      s1_byte_r <= in_byte;
    end
  end

  // key update
  always_comb begin
    app_diff   = s1_byte_r - kssc_pkg::CHAR_A;
    app_letter = app_diff[4:0];
    app_ok     = kssc_pkg::is_upper(s1_byte_r) && !used_r[app_letter]
                 && (length_r < 5'(kssc_pkg::ALPHA_SIZE));
    used_nxt   = used_r;
    length_nxt = length_r;
    order_nxt  = order_r;
    below_nxt  = below_r;
    if (do_step) begin
      unique case (s1_func_r)
        kssc_pkg::FUNC_CLEAR: begin
          used_nxt   = '0;
          length_nxt = '0;
          below_nxt  = '0;
        end
        kssc_pkg::FUNC_APPEND: begin
          if (app_ok) begin
            used_nxt[app_letter]  = 1'b1;
            length_nxt            = length_r + 5'd1;
            order_nxt[length_r]   = app_letter;
            for (int k = 0; k < kssc_pkg::ALPHA_SIZE; k++) begin
              if (5'(k) > app_letter) begin
                below_nxt[k] = below_r[k] + 5'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      length_r <= '0;
      below_r  <= '0;
    end else begin
      used_r   <= used_nxt;
      length_r <= length_nxt;
      below_r  <= below_nxt;
    end
  end

  always_ff @(posedge clk) begin
    order_r <= order_nxt;
  end

  // result register
  always_comb begin
    priority if (do_step && s1_encode) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step && s1_encode) begin
      out_byte_r <= map_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

endmodule

@@ sv/kssc_checker.sv @@
// port-level checks for the keyword shift substitution cipher, bound to the top level
// depends on kssc_pkg and keyword_shift_substitution_cipher_defines.svh
`include "keyword_shift_substitution_cipher_defines.svh"

module kssc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte
);

  // no result right after reset
  `KSSC_ASSERT_NEXT(a_reset_idle, clk, 1'b0, !rst_n, !out_valid)

  // a waiting result transaction holds
  `KSSC_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && out_stall,
                    out_valid && $stable(out_byte))

  // input side waits only behind a blocked result
  `KSSC_ASSERT_NOW(a_stall_cause, clk, !rst_n, in_stall, out_valid && out_stall)

  // a fresh result comes from an encode transaction accepted into the input register before it
  `KSSC_ASSERT_NOW(a_result_source, clk, !rst_n, $rose(out_valid) && $past(rst_n, 2),
                   $past(in_valid && !in_stall && (in_func == kssc_pkg::FUNC_ENCODE), 2))

endmodule

bind keyword_shift_substitution_cipher kssc_checker u_kssc_checker (.*);

@@ verif/keyword_shift_substitution_cipher_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the keyword shift substitution cipher
// depends on kssc_pkg and keyword_shift_substitution_cipher; predicts every enciphered byte
module keyword_shift_substitution_cipher_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_shift_distance = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = kssc_pkg::FUNC_CLEAR;
  logic [7:0] in_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;

  // predictor state
  logic [4:0] cipher_key_order [kssc_pkg::ALPHA_SIZE];
  logic [kssc_pkg::ALPHA_SIZE-1:0] cipher_key_mask = '0;
  int cipher_key_len = 0;
  logic [4:0] cipher_shift = '0;
  logic [7:0] cipher_expected_q [$];

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cycle_count = 0;
  bit sender_no_gaps = 0;

  int hold_req = 0;
  int hold_left = 0;
  int rx_left = 0;
  logic rx_level = 1'b0;

  keyword_shift_substitution_cipher dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_shift_distance(cfg_shift_distance),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               cipher_expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [7:0] encipher_byte(input logic [7:0] b);
    logic [7:0] r;
    int q, rank;
    bit found;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      q = (int'(b - 8'h41) + kssc_pkg::ALPHA_SIZE
           - (int'(cipher_shift) % kssc_pkg::ALPHA_SIZE)) % kssc_pkg::ALPHA_SIZE;
      if (q < cipher_key_len) begin
        r = 8'h41 + 8'(cipher_key_order[q]);
      end else begin
        rank = q - cipher_key_len;
        found = 0;
        r = 8'h41;
        for (int n = 0; n < kssc_pkg::ALPHA_SIZE; n++) begin
          if (!found && !cipher_key_mask[n]) begin
            if (rank == 0) begin
              r = 8'h41 + 8'(n);
              found = 1;
            end
            rank--;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic predict_item(input logic [1:0] f, input logic [7:0] b);
    int n;
    case (f)
      kssc_pkg::FUNC_CLEAR: begin
        cipher_key_mask = '0;
        cipher_key_len = 0;
      end
      kssc_pkg::FUNC_APPEND: begin
        if (b >= 8'h41 && b <= 8'h5A) begin
          n = int'(b - 8'h41);
          if (!cipher_key_mask[n] && cipher_key_len < kssc_pkg::ALPHA_SIZE) begin
            cipher_key_order[cipher_key_len] = 5'(n);
            cipher_key_len++;
            cipher_key_mask[n] = 1'b1;
          end
        end
      end
      kssc_pkg::FUNC_ENCODE: cipher_expected_q.push_back(encipher_byte(b));
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (cipher_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%02h", out_byte));
      end else begin
        want = cipher_expected_q.pop_front();
        results_checked++;
        if (out_byte !== want)
          report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h", out_byte, want));
      end
    end
  end

  // receiver: random stall bursts plus requested long hold-offs
  always @(negedge clk) begin
    int r;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (rx_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rx_level = 1'b0;
          rx_left = $urandom_range(1, 20);
        end else if (r < 92) begin
          rx_level = 1'b1;
          rx_left = $urandom_range(1, 3);
        end else begin
          rx_level = 1'b1;
          rx_left = $urandom_range(10, 30);
        end
      end
      out_stall <= rx_level;
      rx_left--;
    end
  end

  function automatic int pick_gap();
    int r;
    if (sender_no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // entered and left at a falling edge; valid stays high for a back-to-back transaction
  task automatic send_item(input logic [1:0] f, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_item(f, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (cipher_expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_shift(input logic [4:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_shift_distance <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cipher_shift = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_letter();
    return 8'h41 + 8'($urandom_range(0, kssc_pkg::ALPHA_SIZE - 1));
  endfunction

  task automatic test_empty_key();
    // empty key at reset distance: letters map to themselves, others pass
    send_item(kssc_pkg::FUNC_ENCODE, "A");
    send_item(kssc_pkg::FUNC_ENCODE, "Z");
    send_item(kssc_pkg::FUNC_ENCODE, 8'h40);
    send_item(kssc_pkg::FUNC_ENCODE, 8'h5B);
    send_item(kssc_pkg::FUNC_ENCODE, 8'h00);
    send_item(kssc_pkg::FUNC_ENCODE, 8'hFF);
    send_item(kssc_pkg::FUNC_ENCODE, "a");
  endtask

  task automatic test_key_edges();
    set_shift(5'd3);
    send_item(kssc_pkg::FUNC_APPEND, "Z");
    send_item(kssc_pkg::FUNC_APPEND, "E");
    send_item(kssc_pkg::FUNC_APPEND, "B");
    send_item(kssc_pkg::FUNC_APPEND, "A");
    send_item(kssc_pkg::FUNC_APPEND, "Z");      // duplicate letter
    send_item(kssc_pkg::FUNC_APPEND, "a");      // lower case ignored
    send_item(kssc_pkg::FUNC_APPEND, 8'hFF);
    send_item(FUNC_UNUSED, "Q");                // unused selector
    send_item(kssc_pkg::FUNC_ENCODE, "A");
    send_item(kssc_pkg::FUNC_ENCODE, "D");
    send_item(kssc_pkg::FUNC_ENCODE, "H");
    send_item(kssc_pkg::FUNC_ENCODE, "Z");
    send_item(kssc_pkg::FUNC_ENCODE, 8'h60);
    send_item(kssc_pkg::FUNC_CLEAR, 8'hFF);
    send_item(kssc_pkg::FUNC_ENCODE, "M");
  endtask

  task automatic test_long_holdoff();
    logic [7:0] b;
    drain_results();
    send_item(kssc_pkg::FUNC_CLEAR, 8'h00);
    send_item(kssc_pkg::FUNC_APPEND, random_letter());
    send_item(kssc_pkg::FUNC_APPEND, random_letter());
    sender_no_gaps = 1;
    hold_req = 150;
    for (int i = 0; i < 40; i++) begin
      b = random_letter();
      send_item(kssc_pkg::FUNC_ENCODE, b);
    end
    sender_no_gaps = 0;
    while (hold_req != 0 || hold_left != 0) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    // sender waits for every pending result before going on
    drain_results();
  endtask

  task automatic run_random_items(input int count);
    int start, r, nkey, nenc, tmp, j;
    int perm [kssc_pkg::ALPHA_SIZE];
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        if ($urandom_range(0, 4) != 0) send_item(kssc_pkg::FUNC_CLEAR, 8'($urandom()));
        if ($urandom_range(0, 9) == 0) begin
          // whole alphabet as key, in random order
          for (int i = 0; i < kssc_pkg::ALPHA_SIZE; i++) perm[i] = i;
          for (int i = kssc_pkg::ALPHA_SIZE - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          for (int i = 0; i < kssc_pkg::ALPHA_SIZE; i++)
            send_item(kssc_pkg::FUNC_APPEND, 8'h41 + 8'(perm[i]));
          if ($urandom_range(0, 1)) send_item(kssc_pkg::FUNC_APPEND, random_letter());
        end else begin
          nkey = $urandom_range(0, 12);
          for (int i = 0; i < nkey; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(kssc_pkg::FUNC_APPEND, 8'($urandom()));
            else send_item(kssc_pkg::FUNC_APPEND, random_letter());
          end
        end
        nenc = $urandom_range(3, 15);
        for (int i = 0; i < nenc; i++) begin
          if ($urandom_range(0, 99) < 85) send_item(kssc_pkg::FUNC_ENCODE, random_letter());
          else send_item(kssc_pkg::FUNC_ENCODE, 8'($urandom()));
        end
      end else begin
        nenc = $urandom_range(1, 6);
        for (int i = 0; i < nenc; i++)
          send_item(2'($urandom_range(0, 3)), 8'($urandom()));
      end
    end
  endtask

  task automatic test_random_phases();
    logic [4:0] shifts [7];
    shifts = '{5'd25, 5'd31, 5'd0, 5'd13, 5'd26, 5'($urandom()), 5'd1};
    foreach (shifts[k]) begin
      set_shift(shifts[k]);
      run_random_items(100);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_key();
    test_key_edges();
    test_long_holdoff();
    test_random_phases();
    drain_results();
    $display("sent %0d transactions, checked %0d enciphered bytes", items_sent,
             results_checked);
    $display("shift settings 0, 1, 3, 13, 25, 26 and 31 with keys up to the full alphabet");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/kssc_pkg.sv
sv/kssc_map.sv
sv/keyword_shift_substitution_cipher.sv
sv/kssc_checker.sv
verif/keyword_shift_substitution_cipher_tb.sv
